@@ hw/rtl/ppsched_pkg.sv @@
package ppsched_pkg;

	localparam int NUM_CLASSES        = 4;
	localparam int QUEUE_DEPTH        = 64;
	localparam int MAX_DATAGRAM_BYTES = 1500;
	localparam int MAX_BURST          = 16;
	localparam int RESULT_CAP         = 16;

	localparam int CLS_W     = $clog2(NUM_CLASSES);
	localparam int CLS_CNT_W = $clog2(NUM_CLASSES + 1);
	localparam int IDX_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W    = CLS_W + IDX_W;
	localparam int MEM_DEPTH = 2 ** ADDR_W;
	localparam int VBQ_W     = $clog2(QUEUE_DEPTH * 16383 + 1);
	localparam int BURST_CAP = (MAX_BURST < RESULT_CAP) ? MAX_BURST : RESULT_CAP;
	localparam int LIM_W     = $clog2(BURST_CAP + 1);

	localparam int RATE_W  = 34;
	localparam int TIME_W  = 48;
	localparam int DELAY_W = 44;
	localparam int TOK_W   = 50;
	localparam int A_W     = 48;
	localparam int B_W     = 34;
	localparam int P_W     = A_W + B_W;

	localparam int WINDOW_US     = 20000;
	localparam int NEED_PER_BYTE = 8 * 1000000;
	localparam longint FLOOR_UNITS = longint'(MAX_DATAGRAM_BYTES) * 64 * 1000000;

	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_DEQUEUE = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	localparam int CLASS_CONTROL = 0;
	localparam int CLASS_AUDIO   = 1;
	localparam int CLASS_VIDEO   = 2;

	localparam logic [2:0] CFG_VIDEO_RATE    = 3'd0;
	localparam logic [2:0] CFG_LIMIT_CONTROL = 3'd1;
	localparam logic [2:0] CFG_LIMIT_OTHER   = 3'd4;

	typedef struct packed {
		logic [15:0]       desc;
		logic [13:0]       len;
		logic [TIME_W-1:0] deadline;
	} entry_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic           start;
		logic           div;
		logic [A_W-1:0] a;
		logic [B_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic           done;
		logic [P_W-1:0] res;
	} alu_rsp_t;

	typedef struct packed {
		logic               accepted;
		logic               packet_valid;
		logic [15:0]        desc;
		logic [13:0]        len;
		logic [1:0]         cls;
		logic [DELAY_W-1:0] delay;
		logic               last;
	} result_t;

	function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
			logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
		if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) s = s - (CNT_W + 1)'(QUEUE_DEPTH);
		return s[IDX_W-1:0];
	endfunction

endpackage

@@ hw/rtl/ppsched_mem.sv @@
module ppsched_mem (
	input  logic                  clk,
	input  ppsched_pkg::mem_req_t req,
	output ppsched_pkg::entry_t   rd_q
);

	ppsched_pkg::entry_t mem [ppsched_pkg::MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en) rd_q <= mem[req.rd_addr];
	end

endmodule

@@ hw/rtl/ppsched_alu.sv @@
// serial multiply (one multiplier bit per cycle) and restoring divide
module ppsched_alu (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ppsched_pkg::alu_req_t req,
	output ppsched_pkg::alu_rsp_t rsp
);

	localparam int A_W   = ppsched_pkg::A_W;
	localparam int B_W   = ppsched_pkg::B_W;
	localparam int P_W   = ppsched_pkg::P_W;
	localparam int CNT_W = $clog2(A_W + 1);

	logic             run_q;
	logic             div_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [B_W-1:0]   rem_q;
	logic [P_W-1:0]   acc_q;
	logic [B_W:0]     trial;
	logic             fits;

	assign trial = {rem_q, a_q[A_W-1]};
	assign fits  = trial >= {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				div_q <= req.div;
				a_q   <= req.a;
				b_q   <= req.b;
				rem_q <= '0;
				acc_q <= '0;
				cnt_q <= req.div ? CNT_W'(A_W) : CNT_W'(B_W);
			end else if (run_q) begin
				if (div_q) begin
					rem_q <= fits ? B_W'(trial - {1'b0, b_q}) : trial[B_W-1:0];
					a_q   <= {a_q[A_W-2:0], fits};
				end else begin
					acc_q <= (acc_q << 1) + (b_q[B_W-1] ? P_W'(a_q) : '0);
					b_q   <= b_q << 1;
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = div_q ? P_W'(a_q) : acc_q;

endmodule

@@ hw/rtl/priority_packet_scheduler_token_bucket.sv @@
// Strict-priority scheduler, four class FIFOs in one shared entry RAM, video
// gated by a token bucket. Results come out as one-cycle result_strobe pulses
// that cannot be held off; last marks the final result of an item. An enqueue
// checks the class and reads the queue head, may drop the oldest entry of a
// full video or other queue, then writes. A dequeue burst runs the expiry
// scan (one RAM read per queued entry, compaction write behind it), the refill
// (serial multiplier, one bit per cycle), then serves packets, checking each
// video head against the token bucket, and finishes. A delay query runs a
// serial multiply, then a serial divide. A zero burst, a query at zero rate and
// an unknown operation answer in the cycle after start without raising busy.
// Each result strobe follows the cycle that produced it; configuration is
// taken only while idle.
module priority_packet_scheduler_token_bucket (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        operation,
	input  logic [1:0]                        traffic_class,
	input  logic [15:0]                       descriptor,
	input  logic [13:0]                       length_bytes,
	input  logic [47:0]                       deadline_us,
	input  logic [47:0]                       now_us,
	input  logic [4:0]                        burst_limit,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [2:0]                        cfg_index,
	input  logic [33:0]                       cfg_data,
	output logic                              result_strobe,
	output logic                              accepted,
	output logic                              packet_valid,
	output logic [15:0]                       sent_descriptor,
	output logic [13:0]                       sent_length,
	output logic [1:0]                        sent_class,
	output logic [43:0]                       delay_us,
	output logic                              last
);

	localparam int NCLS   = ppsched_pkg::NUM_CLASSES;
	localparam int CLS_W  = ppsched_pkg::CLS_W;
	localparam int CCW    = ppsched_pkg::CLS_CNT_W;
	localparam int IDX_W  = ppsched_pkg::IDX_W;
	localparam int CNT_W  = ppsched_pkg::CNT_W;
	localparam int VBQ_W  = ppsched_pkg::VBQ_W;
	localparam int LIM_W  = ppsched_pkg::LIM_W;
	localparam int TOK_W  = ppsched_pkg::TOK_W;
	localparam int A_W    = ppsched_pkg::A_W;
	localparam int B_W    = ppsched_pkg::B_W;
	localparam int P_W    = ppsched_pkg::P_W;
	localparam int DLY_W  = ppsched_pkg::DELAY_W;
	localparam logic [TOK_W-1:0] FLOOR_TOK = TOK_W'(ppsched_pkg::FLOOR_UNITS);
	localparam logic [CCW-1:0]   C_VID = CCW'(ppsched_pkg::CLASS_VIDEO);
	localparam logic [CCW-1:0]   C_CTL = CCW'(ppsched_pkg::CLASS_CONTROL);
	localparam logic [CCW-1:0]   C_AUD = CCW'(ppsched_pkg::CLASS_AUDIO);

	typedef enum logic [18:0] {
		S_IDLE      = 19'h00001,
		S_ENQ_CHK   = 19'h00002,
		S_ENQ_POP   = 19'h00004,
		S_ENQ_WR    = 19'h00008,
		S_DEQ_CHK   = 19'h00010,
		S_DEQ_DAT   = 19'h00020,
		S_REF_GO    = 19'h00040,
		S_REF_TOP   = 19'h00080,
		S_REF_ELAP  = 19'h00100,
		S_REF_ADD   = 19'h00200,
		S_SRV_CHK   = 19'h00400,
		S_SRV_DAT   = 19'h00800,
		S_SRV_NEED  = 19'h01000,
		S_SRV_POP   = 19'h02000,
		S_FIN       = 19'h04000,
		S_QRY_GO    = 19'h08000,
		S_QRY_MUL   = 19'h10000,
		S_QRY_DIVGO = 19'h20000,
		S_QRY_DIV   = 19'h40000
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        count_q [NCLS];
	logic [IDX_W-1:0]        head_q  [NCLS];
	logic [6:0]              limit_q [4];
	logic [TOK_W-1:0]        token_q;
	logic [TOK_W-1:0]        top_q;
	logic [47:0]             time_q;
	logic                    seen_q;
	logic [VBQ_W-1:0]        vbq_q;
	logic [33:0]             rate_q;
	logic [CCW-1:0]          cls_q;
	logic [CNT_W-1:0]        i_q;
	logic [CNT_W-1:0]        kept_q;
	logic [LIM_W-1:0]        served_q;
	logic [LIM_W-1:0]        lim_q;
	logic [15:0]             desc_q;
	logic [13:0]             len_q;
	logic [47:0]             deadline_q;
	logic [47:0]             now_q;
	logic                    pend_q;
	logic [15:0]             pend_desc_q;
	logic [13:0]             pend_len_q;
	logic [1:0]              pend_cls_q;

	ppsched_pkg::mem_req_t   mreq;
	ppsched_pkg::entry_t     rd;
	ppsched_pkg::alu_req_t   areq;
	ppsched_pkg::alu_rsp_t   arsp;
	ppsched_pkg::result_t    emit;
	logic                    emit_en;

	logic [CLS_W-1:0]        cidx;
	logic [CNT_W-1:0]        cnt_c;
	logic [IDX_W-1:0]        head_c;
	logic [CNT_W-1:0]        lim_c;
	logic                    full;
	logic                    take;
	logic [LIM_W-1:0]        lim_in;
	logic [TOK_W-1:0]        top_w;
	logic                    is_vid;

	ppsched_mem u_mem (
		.clk  (clk),
		.req  (mreq),
		.rd_q (rd)
	);

	ppsched_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.rsp    (arsp)
	);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign take      = start && (state_q == S_IDLE);
	assign cidx      = cls_q[CLS_W-1:0];
	assign cnt_c     = count_q[cidx];
	assign head_c    = head_q[cidx];
	assign is_vid    = (cls_q == C_VID);
	assign full      = cnt_c >= lim_c;
	assign top_w     = (arsp.res > P_W'(FLOOR_TOK)) ? arsp.res[TOK_W-1:0] : FLOOR_TOK;
	assign lim_in    = (32'(burst_limit) > ppsched_pkg::BURST_CAP) ?
		LIM_W'(ppsched_pkg::BURST_CAP) : LIM_W'(burst_limit);

	always_comb begin
		logic [31:0] lv;
		lv = (cls_q < CCW'(4)) ? 32'(limit_q[cls_q[1:0]]) : 32'(ppsched_pkg::QUEUE_DEPTH);
		if (lv == 32'd0) lv = 32'd1;
		if (lv > 32'(ppsched_pkg::QUEUE_DEPTH)) lv = 32'(ppsched_pkg::QUEUE_DEPTH);
		lim_c = CNT_W'(lv);
	end

	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_DEQ_CHK: begin
				mreq.rd_en   = i_q < cnt_c;
				mreq.rd_addr = {cidx, ppsched_pkg::wrap_add(head_c, i_q)};
			end
			S_DEQ_DAT: begin
				mreq.wr_en   = rd.deadline > now_q;
				mreq.wr_addr = {cidx, ppsched_pkg::wrap_add(head_c, kept_q)};
				mreq.wr_data = rd;
			end
			S_ENQ_CHK, S_SRV_CHK: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = {cidx, head_c};
			end
			S_ENQ_WR: begin
				mreq.wr_en            = 1'b1;
				mreq.wr_addr          = {cidx, ppsched_pkg::wrap_add(head_c, cnt_c)};
				mreq.wr_data.desc     = desc_q;
				mreq.wr_data.len      = len_q;
				mreq.wr_data.deadline = deadline_q;
			end
			default: mreq = '0;
		endcase
	end

	always_comb begin
		areq = '0;
		unique case (state_q)
			S_REF_GO: begin
				areq.start = 1'b1;
				areq.a     = A_W'(rate_q);
				areq.b     = B_W'(ppsched_pkg::WINDOW_US);
			end
			S_REF_ELAP: begin
				areq.start = 1'b1;
				areq.a     = now_q - time_q;
				areq.b     = rate_q;
			end
			S_SRV_DAT: begin
				areq.start = is_vid;
				areq.a     = A_W'(ppsched_pkg::NEED_PER_BYTE);
				areq.b     = B_W'(rd.len);
			end
			S_QRY_GO: begin
				areq.start = 1'b1;
				areq.a     = A_W'(ppsched_pkg::NEED_PER_BYTE);
				areq.b     = B_W'(vbq_q);
			end
			S_QRY_DIVGO: begin
				areq.start = 1'b1;
				areq.div   = 1'b1;
				areq.a     = arsp.res[A_W-1:0];
				areq.b     = rate_q;
			end
			default: areq = '0;
		endcase
	end

	always_comb begin
		emit    = '0;
		emit_en = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					priority case (operation)
						ppsched_pkg::OP_ENQUEUE: emit_en = 1'b0;
						ppsched_pkg::OP_DEQUEUE: emit_en = (lim_in == '0);
						ppsched_pkg::OP_QUERY: begin
							emit_en    = (rate_q == '0);
							emit.delay = '1;
						end
						default: emit_en = 1'b1;
					endcase
				end
				emit.last = 1'b1;
			end
			S_ENQ_CHK: begin
				emit_en   = (cls_q >= CCW'(NCLS)) ||
					(full && (cls_q == C_CTL || cls_q == C_AUD));
				emit.last = 1'b1;
			end
			S_ENQ_WR: begin
				emit_en       = 1'b1;
				emit.accepted = 1'b1;
				emit.last     = 1'b1;
			end
			S_SRV_POP, S_FIN: begin
				emit_en           = pend_q || (state_q == S_FIN);
				emit.packet_valid = pend_q;
				emit.desc         = pend_q ? pend_desc_q : '0;
				emit.len          = pend_q ? pend_len_q : '0;
				emit.cls          = pend_q ? pend_cls_q : '0;
				emit.last         = (state_q == S_FIN);
			end
			S_QRY_DIV: begin
				emit_en    = arsp.done;
				emit.delay = (|arsp.res[A_W-1:DLY_W]) ? '1 : arsp.res[DLY_W-1:0];
				emit.last  = 1'b1;
			end
			default: emit_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= emit_en;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			accepted        <= emit.accepted;
			packet_valid    <= emit.packet_valid;
			sent_descriptor <= emit.desc;
			sent_length     <= emit.len;
			sent_class      <= emit.cls;
			delay_us        <= emit.delay;
			last            <= emit.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			for (int k = 0; k < NCLS; k++) begin
				count_q[k] <= '0;
				head_q[k]  <= '0;
			end
			for (int k = 0; k < 4; k++) limit_q[k] <= 7'd64;
			token_q  <= '0;
			time_q   <= '0;
			seen_q   <= 1'b0;
			vbq_q    <= '0;
			rate_q   <= '0;
			cls_q    <= '0;
			i_q      <= '0;
			kept_q   <= '0;
			served_q <= '0;
			lim_q    <= '0;
			pend_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ppsched_pkg::CFG_VIDEO_RATE) begin
					rate_q <= cfg_data;
					seen_q <= 1'b0;
				end else if (cfg_index >= ppsched_pkg::CFG_LIMIT_CONTROL &&
						cfg_index <= ppsched_pkg::CFG_LIMIT_OTHER) begin
					limit_q[2'(cfg_index - ppsched_pkg::CFG_LIMIT_CONTROL)] <= cfg_data[6:0];
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						desc_q     <= descriptor;
						len_q      <= length_bytes;
						deadline_q <= deadline_us;
						now_q      <= now_us;
						lim_q      <= lim_in;
						priority case (operation)
							ppsched_pkg::OP_ENQUEUE: begin
								cls_q   <= CCW'(traffic_class);
								state_q <= S_ENQ_CHK;
							end
							ppsched_pkg::OP_DEQUEUE: begin
								cls_q    <= '0;
								i_q      <= '0;
								kept_q   <= '0;
								served_q <= '0;
								pend_q   <= 1'b0;
								if (lim_in != '0) state_q <= S_DEQ_CHK;
							end
							ppsched_pkg::OP_QUERY: begin
								if (rate_q != '0) state_q <= S_QRY_GO;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ENQ_CHK: begin
					if (cls_q >= CCW'(NCLS)) begin
						state_q <= S_IDLE;
					end else if (full) begin
						if (cls_q == C_CTL || cls_q == C_AUD) begin
							state_q <= S_IDLE;
						end else if (is_vid) begin
							state_q <= S_ENQ_POP;
						end else begin
							head_q[cidx]  <= ppsched_pkg::wrap_add(head_c, CNT_W'(1));
							count_q[cidx] <= cnt_c - 1'b1;
							state_q       <= S_ENQ_WR;
						end
					end else begin
						state_q <= S_ENQ_WR;
					end
				end
				S_ENQ_POP: begin
					vbq_q         <= vbq_q - VBQ_W'(rd.len);
					head_q[cidx]  <= ppsched_pkg::wrap_add(head_c, CNT_W'(1));
					count_q[cidx] <= cnt_c - 1'b1;
					state_q       <= S_ENQ_WR;
				end
				S_ENQ_WR: begin
					count_q[cidx] <= cnt_c + 1'b1;
					if (is_vid) vbq_q <= vbq_q + VBQ_W'(len_q);
					state_q <= S_IDLE;
				end
				S_DEQ_CHK: begin
					if (i_q < cnt_c) begin
						state_q <= S_DEQ_DAT;
					end else begin
						count_q[cidx] <= kept_q;
						i_q           <= '0;
						kept_q        <= '0;
						if (cls_q == CCW'(NCLS - 1)) begin
							cls_q   <= '0;
							state_q <= S_REF_GO;
						end else begin
							cls_q <= cls_q + 1'b1;
						end
					end
				end
				S_DEQ_DAT: begin
					if (rd.deadline > now_q) begin
						kept_q <= kept_q + 1'b1;
					end else if (is_vid) begin
						vbq_q <= vbq_q - VBQ_W'(rd.len);
					end
					i_q     <= i_q + 1'b1;
					state_q <= S_DEQ_CHK;
				end
				S_REF_GO: state_q <= S_REF_TOP;
				S_REF_TOP: begin
					if (arsp.done) begin
						top_q <= top_w;
						if (!seen_q) begin
							seen_q  <= 1'b1;
							token_q <= top_w;
							time_q  <= now_q;
							state_q <= S_SRV_CHK;
						end else if (token_q >= top_w) begin
							token_q <= top_w;
							time_q  <= now_q;
							state_q <= S_SRV_CHK;
						end else if (now_q > time_q && rate_q != '0) begin
							state_q <= S_REF_ELAP;
						end else begin
							time_q  <= now_q;
							state_q <= S_SRV_CHK;
						end
					end
				end
				S_REF_ELAP: state_q <= S_REF_ADD;
				S_REF_ADD: begin
					if (arsp.done) begin
						if (arsp.res > P_W'(top_q - token_q)) token_q <= top_q;
						else token_q <= token_q + arsp.res[TOK_W-1:0];
						time_q  <= now_q;
						state_q <= S_SRV_CHK;
					end
				end
				S_SRV_CHK: begin
					if (served_q == lim_q || cls_q == CCW'(NCLS)) begin
						state_q <= S_FIN;
					end else if (cnt_c == '0) begin
						cls_q <= cls_q + 1'b1;
					end else begin
						state_q <= S_SRV_DAT;
					end
				end
				S_SRV_DAT: state_q <= is_vid ? S_SRV_NEED : S_SRV_POP;
				S_SRV_NEED: begin
					if (arsp.done) begin
						if (arsp.res > P_W'(token_q)) begin
							cls_q   <= cls_q + 1'b1;
							state_q <= S_SRV_CHK;
						end else begin
							token_q <= token_q - arsp.res[TOK_W-1:0];
							state_q <= S_SRV_POP;
						end
					end
				end
				S_SRV_POP: begin
					head_q[cidx]  <= ppsched_pkg::wrap_add(head_c, CNT_W'(1));
					count_q[cidx] <= cnt_c - 1'b1;
					if (is_vid) vbq_q <= vbq_q - VBQ_W'(rd.len);
					pend_q      <= 1'b1;
					pend_desc_q <= rd.desc;
					pend_len_q  <= rd.len;
					pend_cls_q  <= cls_q[1:0];
					served_q    <= served_q + 1'b1;
					cls_q       <= '0;
					state_q     <= S_SRV_CHK;
				end
				S_FIN: begin
					pend_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				S_QRY_GO: state_q <= S_QRY_MUL;
				S_QRY_MUL: begin
					if (arsp.done) state_q <= S_QRY_DIVGO;
				end
				S_QRY_DIVGO: state_q <= S_QRY_DIV;
				S_QRY_DIV: begin
					if (arsp.done) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
